// ----- hw/rtl/rtc_pkg.sv -----
package rtc_pkg;

  // Sine table geometry
  localparam int SINE_BITS    = 8;
  localparam int SINE_ENTRIES = 1 << SINE_BITS;
  localparam int SINE_W       = 17;  // Q0.16, range 0..65536

  // Text codes
  localparam logic [7:0] NEWLINE = 8'd10;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Register reset values
  localparam logic [15:0] START_PHASE_RESET   = 16'd0;
  localparam logic [15:0] COLUMN_STEP_RESET   = 16'd522;
  localparam logic [15:0] LINE_STEP_RESET     = 16'd1043;
  localparam logic [8:0]  PASTEL_OFFSET_RESET = 9'd115;
  localparam logic [8:0]  OFFSET_ONE          = 9'd256;

  // Fixed-point sine constants (Q2.30)
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam int     TAYLOR_TERMS = 12;
  // (2k)*(2k+1) divisors of the series; slot zero is unused
  localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'sd1, 64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
    64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506
  };

  typedef enum logic [1:0] {
    REG_START_PHASE   = 2'd0,
    REG_COLUMN_STEP   = 2'd1,
    REG_LINE_STEP     = 2'd2,
    REG_PASTEL_OFFSET = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] start_phase;
    logic [15:0] column_step;
    logic [15:0] line_step;
    logic [8:0]  pastel_offset;
  } rtc_cfg_t;

  // One queued character with its three table indices
  typedef struct packed {
    logic [7:0]           character;
    logic [SINE_BITS-1:0] idx_red;
    logic [SINE_BITS-1:0] idx_green;
    logic [SINE_BITS-1:0] idx_blue;
  } rtc_item_t;

  typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_table_t;

  // sin(v * (pi/2) / SINE_ENTRIES) in Q30, v in 0..SINE_ENTRIES
  function automatic longint sin_q30(input longint v);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (v * HALF_PI_Q30) / SINE_ENTRIES;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int k = 1; k < TAYLOR_TERMS; k++) begin
      term = ((term * x2) >>> 30) / TAYLOR_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return sum;
  endfunction

  // Table of (1+sin)/2 in Q0.16, folded into the first quadrant
  function automatic sine_table_t build_sine_table();
    sine_table_t tab;
    longint      v;
    longint      s;
    logic        neg;
    tab = '0;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      v   = 4 * longint'(k);
      neg = 1'b0;
      if (v > 2 * SINE_ENTRIES) begin
        v = v - 4 * SINE_ENTRIES;
      end
      if (v > SINE_ENTRIES) begin
        v = 2 * SINE_ENTRIES - v;
      end
      if (v < -SINE_ENTRIES) begin
        v = -2 * SINE_ENTRIES - v;
      end
      if (v < 0) begin
        neg = 1'b1;
        v   = -v;
      end
      s = sin_q30(v);
      if (neg) begin
        tab[k] = SINE_W'((ONE_Q30 - s + 64'sd16384) >>> 15);
      end else begin
        tab[k] = SINE_W'((ONE_Q30 + s + 64'sd16384) >>> 15);
      end
    end
    return tab;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ----- hw/rtl/rtc_front.sv -----
module rtc_front
  import rtc_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  rtc_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] character,
  input  logic      queue_full,
  output logic      push,
  output rtc_item_t push_item
);

  localparam logic [PHASE_BITS-1:0] THIRD =
    PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
  localparam logic [PHASE_BITS-1:0] TWO_THIRDS =
    PHASE_BITS'(((64'd2 << PHASE_BITS) + 64'd1) / 64'd3);

  logic [PHASE_BITS-1:0] column_phase;
  logic [PHASE_BITS-1:0] column_phase_next;
  logic [PHASE_BITS-1:0] line_phase;
  logic [PHASE_BITS-1:0] line_phase_next;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_green;
  logic [PHASE_BITS-1:0] phase_blue;
  logic                  accept;
  logic                  is_newline;

  // Handshake: take a beat whenever the queue has room
  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign push       = accept;
  assign is_newline = (character == NEWLINE);

  // Colour phase of this character, wrapping modulo one turn
  assign phase       = PHASE_BITS'(cfg.start_phase) + column_phase + line_phase;
  assign phase_green = phase + THIRD;
  assign phase_blue  = phase + TWO_THIRDS;

  // Table index is the top bits of each channel phase
  always_comb begin
    push_item.character = character;
    push_item.idx_red   = phase[PHASE_BITS-1 -: SINE_BITS];
    push_item.idx_green = phase_green[PHASE_BITS-1 -: SINE_BITS];
    push_item.idx_blue  = phase_blue[PHASE_BITS-1 -: SINE_BITS];
  end

  // Newline restarts the column and moves to the next line
  always_comb begin
    column_phase_next = column_phase;
    line_phase_next   = line_phase;
    if (accept) begin
      if (is_newline) begin
        column_phase_next = '0;
        line_phase_next   = line_phase + PHASE_BITS'(cfg.line_step);
      end else begin
        column_phase_next = column_phase + PHASE_BITS'(cfg.column_step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_phase <= '0;
      line_phase   <= '0;
    end else begin
      column_phase <= column_phase_next;
      line_phase   <= line_phase_next;
    end
  end

  a_newline_clears_column: assert property (@(posedge clk) disable iff (rst)
    (accept && is_newline) |=> (column_phase == '0))
    else $error("column phase not cleared after newline");

  a_line_holds_midline: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_newline) |=> $stable(line_phase))
    else $error("line phase moved on an ordinary character");

endmodule

// ----- hw/rtl/rtc_queue.sv -----
module rtc_queue
  import rtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rtc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output rtc_item_t pop_item
);

  rtc_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic [QUEUE_PTR_W:0]   count_next;

  assign full      = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];

  // Occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !pop_valid))
    else $error("queue written when full or read when empty");

endmodule

// ----- hw/rtl/rtc_back.sv -----
module rtc_back
  import rtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [8:0] pastel_offset,
  input  logic       queue_valid,
  input  rtc_item_t  queue_item,
  output logic       queue_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] character_out,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic [8:0]  off_sat;
  logic [8:0]  off_inv;

  // Stage 1: table lookup
  logic                        v1;
  logic [7:0]                  s1_char;
  logic [2:0][SINE_W-1:0]      s1_u;
  logic [2:0][SINE_BITS-1:0]   idx;

  // Stage 2: blended level, 25 bits hold up to 256 * 65536
  logic                        v2;
  logic [7:0]                  s2_char;
  logic [2:0][24:0]            s2_acc;
  logic [2:0][24:0]            acc_next;

  // Stage 3: output register
  logic [2:0][7:0]             level_next;
  logic [2:0][7:0]             s3_level;
  logic                        s1_ready;
  logic                        s2_ready;
  logic                        s3_ready;

  // Offset saturates at one
  assign off_sat = (pastel_offset > OFFSET_ONE) ? OFFSET_ONE : pastel_offset;
  assign off_inv = OFFSET_ONE - off_sat;

  // Elastic stall chain
  assign s3_ready  = !out_valid || out_ready;
  assign s2_ready  = !v2 || s3_ready;
  assign s1_ready  = !v1 || s2_ready;
  assign queue_pop = queue_valid && s1_ready;

  assign idx[0] = queue_item.idx_red;
  assign idx[1] = queue_item.idx_green;
  assign idx[2] = queue_item.idx_blue;

  // off*65536 + (256-off)*u per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_next[c] = {off_sat, 16'h0000} + (25'(off_inv) * 25'(s1_u[c]));
    end
  end

  // 255*acc, round to nearest at bit 24, clamp to a byte
  always_comb begin
    logic [32:0] num;
    logic [32:0] rnd;
    for (int c = 0; c < 3; c++) begin
      num = {s2_acc[c], 8'h00} - {8'h00, s2_acc[c]};
      rnd = num + 33'(1 << 23);
      level_next[c] = (rnd[32:24] > 9'd255) ? 8'd255 : rnd[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1 <= queue_valid;
      end
      if (s2_ready) begin
        v2 <= v1;
      end
      if (s3_ready) begin
        out_valid <= v2;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (queue_pop) begin
      s1_char <= queue_item.character;
      for (int c = 0; c < 3; c++) begin
        s1_u[c] <= SINE_TABLE[idx[c]];
      end
    end
    if (s2_ready && v1) begin
      s2_char <= s1_char;
      s2_acc  <= acc_next;
    end
    if (s3_ready && v2) begin
      character_out <= s2_char;
      s3_level      <= level_next;
    end
  end

  assign red   = s3_level[0];
  assign green = s3_level[1];
  assign blue  = s3_level[2];

  a_out_from_stage2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v2))
    else $error("result appeared without a beat in stage 2");

  a_stall_keeps_stage2: assert property (@(posedge clk) disable iff (rst)
    (v2 && out_valid && !out_ready) |=> v2)
    else $error("stage 2 beat lost during output stall");

endmodule

// ----- hw/rtl/rainbow_text_colorizer.sv -----
// Rainbow text colorizer.
// Input channel: one text byte per beat on character (in_valid/in_ready).
// Output channel: the same byte on character_out with red, green and blue
// (out_valid/out_ready), one result beat per input beat, in order.
// Configuration channel: cfg_index selects start_phase (0), column_step (1),
// line_step (2) or pastel_offset (3); cfg_data carries the value. cfg_ready
// is always high; write only while no beats are in flight.
// Path: an accepted byte is written into the queue, then registered through
// table lookup, blend multiply, and scale and round, in that order.
// Throughput: one byte per cycle when not stalled; the front adds phases
// combinationally, the back has three stages and one multiplier per channel.
// Reset clears the column and line phases and loads the default registers.
// When the receiver stalls, results back up through the pipeline into a
// four-entry queue; in_ready drops only once that queue is full.
module rainbow_text_colorizer
  import rtc_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character_out,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rtc_cfg_t  cfg;
  logic      queue_full;
  logic      push;
  rtc_item_t push_item;
  logic      pop;
  logic      pop_valid;
  rtc_item_t pop_item;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_phase   <= START_PHASE_RESET;
      cfg.column_step   <= COLUMN_STEP_RESET;
      cfg.line_step     <= LINE_STEP_RESET;
      cfg.pastel_offset <= PASTEL_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_PHASE:   cfg.start_phase   <= cfg_data;
        REG_COLUMN_STEP:   cfg.column_step   <= cfg_data;
        REG_LINE_STEP:     cfg.line_step     <= cfg_data;
        REG_PASTEL_OFFSET: cfg.pastel_offset <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  rtc_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .character  (character),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  rtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  rtc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pastel_offset (cfg.pastel_offset),
    .queue_valid   (pop_valid),
    .queue_item    (pop_item),
    .queue_pop     (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .character_out (character_out),
    .red           (red),
    .green         (green),
    .blue          (blue)
  );

endmodule

// ----- verif/rainbow_text_colorizer_test.sv -----
`timescale 1ns / 100ps

module rainbow_text_colorizer_test;
  import rtc_pkg::*;

  localparam int HUE_BITS = 16;
  localparam int LUT_BITS = 8;
  localparam int LUT_SIZE = 1 << LUT_BITS;
  localparam logic [HUE_BITS-1:0] THIRD_TURN      = HUE_BITS'(((1 << HUE_BITS) + 1) / 3);
  localparam logic [HUE_BITS-1:0] TWO_THIRDS_TURN = HUE_BITS'(((2 << HUE_BITS) + 1) / 3);
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;  // pi/2 in Q2.30
  localparam longint UNIT_Q30         = 64'sd1073741824;
  localparam int SERIES_TERMS    = 12;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int RANDOM_PHASES   = 5;
  localparam int BEATS_PER_PHASE = 96;

  // One line of the directed script: a register write or a text beat
  typedef struct {
    bit          is_write;
    cfg_reg_t    reg_sel;
    logic [15:0] value;
    logic [7:0]  text_byte;
    bit          color_known;
  } script_row_t;

  typedef struct {
    logic [7:0] text_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colored_char_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  character = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  character_out;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Pinned colour travels with the beat so the checker sees it at acceptance
  logic        pin_known = 1'b0;
  logic [7:0]  pin_level = '0;

  logic [16:0]   wave_lut [LUT_SIZE];
  colored_char_t color_due [$];
  script_row_t   script [$];

  // Predictor copy of registers and phase accumulators
  rtc_cfg_t          shadow_cfg = '{START_PHASE_RESET, COLUMN_STEP_RESET,
                                    LINE_STEP_RESET, PASTEL_OFFSET_RESET};
  logic [HUE_BITS-1:0] col_acc = '0;
  logic [HUE_BITS-1:0] row_acc = '0;

  int beats_sent    = 0;
  int beats_checked = 0;
  int mismatch_count = 0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  rainbow_text_colorizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .character    (character),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .character_out(character_out),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sin(v * (pi/2) / LUT_SIZE) in Q30 by truncated Taylor series
  function automatic longint taylor_sine_q30(longint v);
    longint x;
    longint x_sq;
    longint term;
    longint acc;
    int     k;
    x    = (v * QUARTER_TURN_Q30) / LUT_SIZE;
    x_sq = (x * x) >>> 30;
    term = x;
    acc  = x;
    for (k = 1; k < SERIES_TERMS; k++) begin
      term = ((term * x_sq) >>> 30) / ((2 * k) * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    if (acc < 0) acc = 0;
    if (acc > UNIT_Q30) acc = UNIT_Q30;
    return acc;
  endfunction

  // (1+sin)/2 lookup in Q0.16, angle folded into the first quadrant
  initial begin : fill_wave_lut
    longint v;
    longint s;
    bit     below;
    for (int k = 0; k < LUT_SIZE; k++) begin
      v = 4 * k;
      if (v > 2 * LUT_SIZE) v = v - 4 * LUT_SIZE;
      if (v > LUT_SIZE) v = 2 * LUT_SIZE - v;
      if (v < -LUT_SIZE) v = -2 * LUT_SIZE - v;
      below = (v < 0);
      if (below) v = -v;
      s = taylor_sine_q30(v);
      wave_lut[k] = below ? 17'((UNIT_Q30 - s + 16384) >>> 15)
                          : 17'((UNIT_Q30 + s + 16384) >>> 15);
    end
  end

  // 255 * (floor + (1 - floor) * u), rounded and clamped
  function automatic logic [7:0] blend_channel(logic [HUE_BITS-1:0] hue,
                                               logic [8:0] floor_q8);
    longint u;
    longint level;
    u = longint'(wave_lut[hue[HUE_BITS-1 -: LUT_BITS]]);
    level = (255 * (longint'(floor_q8) * 65536 + (256 - longint'(floor_q8)) * u)
             + 64'sd8388608) >>> 24;
    if (level > 255) level = 255;
    return level[7:0];
  endfunction

  function automatic script_row_t write_row(cfg_reg_t sel, logic [15:0] value);
    script_row_t row;
    row = '{1'b1, sel, value, 8'd0, 1'b0};
    return row;
  endfunction

  function automatic script_row_t beat_row(logic [7:0] text_byte);
    script_row_t row;
    row = '{1'b0, REG_START_PHASE, 16'd0, text_byte, 1'b0};
    return row;
  endfunction

  // Full floor: every channel saturates to 255
  function automatic script_row_t white_row(logic [7:0] text_byte);
    script_row_t row;
    row = '{1'b0, REG_START_PHASE, 16'd0, text_byte, 1'b1};
    return row;
  endfunction

  // Mostly text with line breaks, some arbitrary bytes
  function automatic logic [7:0] next_text_byte();
    if ($urandom_range(9) < 7) begin
      if ($urandom_range(11) == 0) return NEWLINE;
      return 8'($urandom_range(32, 126));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_setting(logic [15:0] dflt, logic [15:0] top);
    case ($urandom_range(3))
      0: return 16'd0;
      1: return top;
      2: return 16'($urandom);
      default: return dflt;
    endcase
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Predict on every accepted beat, check every result beat
  always @(posedge clk) begin : scoreboard
    logic [HUE_BITS-1:0] hue;
    logic [8:0]          floor_q8;
    colored_char_t       due;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_PHASE:   shadow_cfg.start_phase   = cfg_data;
          REG_COLUMN_STEP:   shadow_cfg.column_step   = cfg_data;
          REG_LINE_STEP:     shadow_cfg.line_step     = cfg_data;
          REG_PASTEL_OFFSET: shadow_cfg.pastel_offset = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        hue = shadow_cfg.start_phase + col_acc + row_acc;
        floor_q8 = (shadow_cfg.pastel_offset > OFFSET_ONE) ? OFFSET_ONE
                                                           : shadow_cfg.pastel_offset;
        due.text_byte = character;
        due.red   = blend_channel(hue, floor_q8);
        due.green = blend_channel(hue + THIRD_TURN, floor_q8);
        due.blue  = blend_channel(hue + TWO_THIRDS_TURN, floor_q8);
        if (pin_known) begin
          due.red   = pin_level;
          due.green = pin_level;
          due.blue  = pin_level;
        end
        color_due.push_back(due);
        // newline is colored first, then starts a new line
        if (character == NEWLINE) begin
          col_acc = '0;
          row_acc = row_acc + shadow_cfg.line_step;
        end else begin
          col_acc = col_acc + shadow_cfg.column_step;
        end
      end
      if (out_valid && out_ready) begin
        if (color_due.size() == 0) begin
          $error("unexpected beat: character_out %0d", character_out);
          mismatch_count++;
        end else begin
          due = color_due.pop_front();
          compare_field("character_out", due.text_byte, character_out);
          compare_field("red", due.red, red);
          compare_field("green", due.green, green);
          compare_field("blue", due.blue, blue);
          beats_checked++;
        end
      end
    end
  end

  // Receiver back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(logic [7:0] text_byte, bit known);
    in_valid  <= 1'b1;
    character <= text_byte;
    pin_known <= known;
    pin_level <= 8'd255;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic sender_gap();
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Hold the sender until every result is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (beats_checked != beats_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [15:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] start, logic [15:0] col_step,
                                logic [15:0] row_step, logic [15:0] pastel);
    write_reg(REG_START_PHASE, start);
    write_reg(REG_COLUMN_STEP, col_step);
    write_reg(REG_LINE_STEP, row_step);
    write_reg(REG_PASTEL_OFFSET, pastel);
  endtask

  initial begin
    // reset defaults first, then full floor, then saturated floor,
    // then all-ones and all-zero steps, then half and quarter turns
    script.push_back(beat_row(8'h41));
    script.push_back(beat_row(8'h00));
    script.push_back(beat_row(8'hFF));
    script.push_back(beat_row(NEWLINE));
    script.push_back(beat_row(8'h62));
    script.push_back(beat_row(NEWLINE));
    script.push_back(beat_row(NEWLINE));
    script.push_back(beat_row(8'h20));
    script.push_back(write_row(REG_PASTEL_OFFSET, 16'd256));
    script.push_back(white_row(8'h55));
    script.push_back(white_row(NEWLINE));
    script.push_back(white_row(8'hAA));
    script.push_back(write_row(REG_PASTEL_OFFSET, 16'h01FF));
    script.push_back(white_row(8'h7F));
    script.push_back(white_row(NEWLINE));
    script.push_back(write_row(REG_PASTEL_OFFSET, 16'd0));
    script.push_back(write_row(REG_START_PHASE, 16'hFFFF));
    script.push_back(write_row(REG_COLUMN_STEP, 16'hFFFF));
    script.push_back(write_row(REG_LINE_STEP, 16'hFFFF));
    script.push_back(beat_row(8'h30));
    script.push_back(beat_row(NEWLINE));
    script.push_back(beat_row(8'h31));
    script.push_back(beat_row(8'h80));
    script.push_back(write_row(REG_START_PHASE, 16'd0));
    script.push_back(write_row(REG_COLUMN_STEP, 16'd0));
    script.push_back(write_row(REG_LINE_STEP, 16'd0));
    script.push_back(beat_row(8'h01));
    script.push_back(beat_row(NEWLINE));
    script.push_back(beat_row(8'h02));
    // upper data bits of the offset write are dropped: 0xFE00 acts as zero
    script.push_back(write_row(REG_COLUMN_STEP, 16'h8000));
    script.push_back(write_row(REG_LINE_STEP, 16'h4000));
    script.push_back(write_row(REG_START_PHASE, 16'h1234));
    script.push_back(write_row(REG_PASTEL_OFFSET, 16'hFE00));
    script.push_back(beat_row(8'h10));
    script.push_back(beat_row(8'hEF));
    script.push_back(beat_row(NEWLINE));
    script.push_back(beat_row(8'h5A));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed script
    gap_pct   = 20;
    stall_pct = 20;
    foreach (script[i]) begin
      if (script[i].is_write) begin
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        sender_gap();
        send_beat(script[i].text_byte, script[i].color_known);
      end
    end

    // random text, new settings per phase, quiet in the last one
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        apply_settings(START_PHASE_RESET, COLUMN_STEP_RESET, LINE_STEP_RESET,
                       16'(PASTEL_OFFSET_RESET));
      end else begin
        apply_settings(pick_setting(START_PHASE_RESET, 16'hFFFF),
                       pick_setting(COLUMN_STEP_RESET, 16'hFFFF),
                       pick_setting(LINE_STEP_RESET, 16'hFFFF),
                       pick_setting(16'(PASTEL_OFFSET_RESET), 16'(OFFSET_ONE)));
      end
      case (phase)
        0: begin gap_pct = 30; stall_pct = 30; end
        1: begin gap_pct = 0;  stall_pct = 50; end
        2: begin gap_pct = 50; stall_pct = 0;  end
        3: begin gap_pct = 15; stall_pct = 15; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (n == BEATS_PER_PHASE / 2) settle();
        sender_gap();
        send_beat(next_text_byte(), 1'b0);
      end
    end

    settle();
    if (color_due.size() != 0) begin
      $error("%0d results never arrived", color_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
